FILE: hw/rtl/bphp_pkg.sv
// Shared types, code tables and constants of the board position packer.
package bphp_pkg;

	localparam logic [1:0] KIND_HEADER = 2'd0;
	localparam logic [1:0] KIND_BOARD  = 2'd1;
	localparam logic [1:0] KIND_HAND   = 2'd2;
	localparam logic [1:0] KIND_FINISH = 2'd3;

	localparam logic [2:0] PIECE_EMPTY = 3'd0;
	localparam logic [2:0] PIECE_GOLD  = 3'd7;

	localparam logic [1:0] STATUS_OK      = 2'd0;
	localparam logic [1:0] STATUS_OVERRUN = 2'd1;
	localparam logic [1:0] STATUS_SHORT   = 2'd2;

	// bytes a finish transfer may produce
	localparam int MAX_RESULTS = 32;
	localparam int CNT_W       = $clog2(MAX_RESULTS + 1);

	localparam int NUM_TYPES = 7;
	localparam logic [2:0] BOX_STEPS = 3'd7;

	localparam int QDEPTH = 4;
	localparam int QPTR_W = $clog2(QDEPTH);
	localparam int QCNT_W = $clog2(QDEPTH + 1);

	// one chunk of record bits, LSB first; pad asks the packer to close the record
	typedef struct packed {
		logic [7:0] bits;
		logic [3:0] len;
		logic       pad;
		logic       fin;
	} op_t;

	typedef struct packed {
		logic done;
		logic record_done;
	} done_t;

	typedef enum logic [1:0] {
		FR_IDLE,
		FR_HDR2,
		FR_FIN,
		FR_WAIT
	} front_state_t;

	function automatic logic [7:0] board_code(input logic [2:0] pk);
		case (pk)
			3'd1:    board_code = 8'h01;
			3'd2:    board_code = 8'h03;
			3'd3:    board_code = 8'h0b;
			3'd4:    board_code = 8'h07;
			3'd5:    board_code = 8'h1f;
			3'd6:    board_code = 8'h3f;
			3'd7:    board_code = 8'h0f;
			default: board_code = 8'h00;
		endcase
	endfunction

	function automatic logic [2:0] board_len(input logic [2:0] pk);
		case (pk)
			3'd1:    board_len = 3'd2;
			3'd2:    board_len = 3'd4;
			3'd3:    board_len = 3'd4;
			3'd4:    board_len = 3'd4;
			3'd5:    board_len = 3'd6;
			3'd6:    board_len = 3'd6;
			3'd7:    board_len = 3'd5;
			default: board_len = 3'd0;
		endcase
	endfunction

	function automatic logic [7:0] box_code(input logic [2:0] pk);
		case (pk)
			3'd1:    box_code = 8'h02;
			3'd2:    box_code = 8'h09;
			3'd3:    box_code = 8'h0d;
			3'd4:    box_code = 8'h0b;
			3'd5:    box_code = 8'h2f;
			3'd6:    box_code = 8'h3f;
			3'd7:    box_code = 8'h1b;
			default: box_code = 8'h00;
		endcase
	endfunction

	function automatic logic [2:0] box_len(input logic [2:0] pk);
		case (pk)
			3'd1:    box_len = 3'd2;
			3'd2:    box_len = 3'd4;
			3'd3:    box_len = 3'd4;
			3'd4:    box_len = 3'd4;
			3'd5:    box_len = 3'd6;
			3'd6:    box_len = 3'd6;
			3'd7:    box_len = 3'd5;
			default: box_len = 3'd0;
		endcase
	endfunction

	// piece-box walk: pawn, lance, knight, silver, gold, bishop, rook
	function automatic logic [2:0] box_order(input logic [2:0] step);
		case (step)
			3'd0:    box_order = 3'd1;
			3'd1:    box_order = 3'd2;
			3'd2:    box_order = 3'd3;
			3'd3:    box_order = 3'd4;
			3'd4:    box_order = 3'd7;
			3'd5:    box_order = 3'd5;
			3'd6:    box_order = 3'd6;
			default: box_order = 3'd1;
		endcase
	endfunction

	// full set per counter slot (slot = piece_kind - 1)
	function automatic logic [4:0] box_init(input logic [2:0] slot);
		case (slot)
			3'd0:    box_init = 5'd18;
			3'd1:    box_init = 5'd4;
			3'd2:    box_init = 5'd4;
			3'd3:    box_init = 5'd4;
			3'd4:    box_init = 5'd2;
			3'd5:    box_init = 5'd2;
			3'd6:    box_init = 5'd4;
			default: box_init = 5'd0;
		endcase
	endfunction

endpackage

FILE: hw/rtl/board_position_huffman_packer.sv
// Top level of the board position prefix-code packer.
//
//  channel  | handshake          | payload
//  ---------+--------------------+-----------------------------------------------
//  input    | in_valid/in_stall  | kind, piece_kind, promoted, owner, turn,
//           |                    | first_king_square, second_king_square
//  output   | out_valid/out_stall| out_byte, last, status
//
// Board items become one chunk in the classifier and hand items at most one; a
// header splits into an 8-bit and a 7-bit chunk. The packer retires one chunk
// per cycle unless a held output byte is stalled, and emits at most one byte
// per cycle through the output register. After the finish transfer the
// classifier walks the box, pushing one chunk per piece left in it and then a
// padding op, and the packer emits the padding bytes; input is held off until
// the record is closed or the finish has spent its 32-byte budget.
// Reset (arst_n low) clears accumulator, byte count, overrun flag and refills
// the piece box. Output stall backs up the packer, then the 4-entry chunk
// queue, then the input.
module board_position_huffman_packer #(
	parameter int RECORD_BITS = 256
) (
	input  logic        clk,
	input  logic        arst_n,

	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  kind,
	input  logic [2:0]  piece_kind,
	input  logic        promoted,
	input  logic        owner,
	input  logic        turn,
	input  logic [6:0]  first_king_square,
	input  logic [6:0]  second_king_square,

	output logic        out_valid,
	input  logic        out_stall,
	output logic [7:0]  out_byte,
	output logic        last,
	output logic [1:0]  status
);

	logic               push;
	bphp_pkg::op_t      push_op;
	logic               q_full;
	logic               pop;
	logic               op_valid;
	bphp_pkg::op_t      op;
	bphp_pkg::done_t    done;

	// classifier: header split, code lookup, piece box walk on finish
	bphp_front u_front (
		.clk                (clk),
		.arst_n             (arst_n),
		.in_valid           (in_valid),
		.in_stall           (in_stall),
		.kind               (kind),
		.piece_kind         (piece_kind),
		.promoted           (promoted),
		.owner              (owner),
		.turn               (turn),
		.first_king_square  (first_king_square),
		.second_king_square (second_king_square),
		.push               (push),
		.push_op            (push_op),
		.q_full             (q_full),
		.done               (done)
	);

	// decouples the classifier from output back-pressure
	bphp_fifo u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_op  (push_op),
		.full     (q_full),
		.pop      (pop),
		.op_valid (op_valid),
		.op       (op)
	);

	// packer: byte assembly, final byte hold, padding and status
	bphp_back #(
		.RECORD_BITS (RECORD_BITS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.op_valid  (op_valid),
		.op        (op),
		.pop       (pop),
		.done      (done),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_byte  (out_byte),
		.last      (last),
		.status    (status)
	);

endmodule

FILE: hw/rtl/bphp_fifo.sv
// Small op queue between the classifier and the bit packer.
module bphp_fifo (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  bphp_pkg::op_t   push_op,
	output logic            full,
	input  logic            pop,
	output logic            op_valid,
	output bphp_pkg::op_t   op
);

	bphp_pkg::op_t                  mem_q [bphp_pkg::QDEPTH];
	logic [bphp_pkg::QPTR_W-1:0]    wr_ptr_q;
	logic [bphp_pkg::QPTR_W-1:0]    rd_ptr_q;
	logic [bphp_pkg::QCNT_W-1:0]    count_q;
	logic                           do_push;
	logic                           do_pop;

	assign full     = (count_q == bphp_pkg::QCNT_W'(bphp_pkg::QDEPTH));
	assign op_valid = (count_q != '0);
	assign op       = mem_q[rd_ptr_q];
	assign do_push  = push && !full;
	assign do_pop   = pop && op_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({do_push, do_pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_op;
		end
	end

	a_ptr_match: assert property (@(posedge clk) disable iff (!arst_n)
		count_q != '0 || wr_ptr_q == rd_ptr_q)
		else $error("queue empty but pointers differ");

endmodule

FILE: hw/rtl/bphp_front.sv
// Classifier: turns input items into bit chunks and walks the piece box on finish.
module bphp_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  logic [1:0]          kind,
	input  logic [2:0]          piece_kind,
	input  logic                promoted,
	input  logic                owner,
	input  logic                turn,
	input  logic [6:0]          first_king_square,
	input  logic [6:0]          second_king_square,
	output logic                push,
	output bphp_pkg::op_t       push_op,
	input  logic                q_full,
	input  bphp_pkg::done_t     done
);

	bphp_pkg::front_state_t state_q;
	bphp_pkg::front_state_t state_n;
	logic [2:0]             step_q;
	logic [6:0]             sq2_q;
	logic [4:0]             box_q [bphp_pkg::NUM_TYPES];

	logic                   accept;
	logic [2:0]             fin_pk;
	logic [2:0]             rd_idx;
	logic [4:0]             box_rd;
	logic                   dec_en;
	logic                   step_inc;
	logic [7:0]             code;
	logic [2:0]             clen;
	logic                   box_ok;

	assign accept   = in_valid && (state_q == bphp_pkg::FR_IDLE) && !q_full;
	assign in_stall = !((state_q == bphp_pkg::FR_IDLE) && !q_full);
	assign fin_pk   = bphp_pkg::box_order(step_q);
	// single read port on the counters
	assign rd_idx   = (state_q == bphp_pkg::FR_FIN) ? fin_pk - 3'd1 : piece_kind - 3'd1;
	assign box_rd   = (rd_idx < 3'(bphp_pkg::NUM_TYPES)) ? box_q[rd_idx] : 5'd0;

	always_comb begin
		state_n = state_q;
		case (state_q)
			bphp_pkg::FR_IDLE: begin
				if (accept && kind == bphp_pkg::KIND_HEADER) begin
					state_n = bphp_pkg::FR_HDR2;
				end else if (accept && kind == bphp_pkg::KIND_FINISH) begin
					state_n = bphp_pkg::FR_FIN;
				end
			end
			bphp_pkg::FR_HDR2: begin
				if (!q_full) begin
					state_n = bphp_pkg::FR_IDLE;
				end
			end
			bphp_pkg::FR_FIN: begin
				if (step_q == bphp_pkg::BOX_STEPS && !q_full) begin
					state_n = bphp_pkg::FR_WAIT;
				end
			end
			bphp_pkg::FR_WAIT: begin
				if (done.done) begin
					state_n = bphp_pkg::FR_IDLE;
				end
			end
			default: state_n = bphp_pkg::FR_IDLE;
		endcase
	end

	always_comb begin
		push     = 1'b0;
		push_op  = '0;
		dec_en   = 1'b0;
		step_inc = 1'b0;
		code     = bphp_pkg::board_code(piece_kind);
		clen     = bphp_pkg::board_len(piece_kind);
		case (state_q)
			bphp_pkg::FR_IDLE: begin
				if (accept) begin
					case (kind)
						bphp_pkg::KIND_HEADER: begin
							push          = 1'b1;
							push_op.bits  = {first_king_square, turn};
							push_op.len   = 4'd8;
						end
						bphp_pkg::KIND_BOARD: begin
							push = 1'b1;
							if (piece_kind == bphp_pkg::PIECE_EMPTY) begin
								push_op.len = 4'd1;
							end else if (piece_kind == bphp_pkg::PIECE_GOLD) begin
								dec_en       = 1'b1;
								push_op.bits = code | ({7'd0, owner} << clen);
								push_op.len  = {1'b0, clen} + 4'd1;
							end else begin
								dec_en       = 1'b1;
								push_op.bits = code | ({7'd0, promoted} << clen)
									| ({7'd0, owner} << ({1'b0, clen} + 4'd1));
								push_op.len  = {1'b0, clen} + 4'd2;
							end
						end
						bphp_pkg::KIND_HAND: begin
							// code without bit 0, a zero promote bit (none for gold), then owner
							if (piece_kind == bphp_pkg::PIECE_GOLD) begin
								push         = 1'b1;
								dec_en       = 1'b1;
								push_op.bits = (code >> 1) | ({7'd0, owner} << (clen - 3'd1));
								push_op.len  = {1'b0, clen};
							end else if (piece_kind != bphp_pkg::PIECE_EMPTY) begin
								push         = 1'b1;
								dec_en       = 1'b1;
								push_op.bits = (code >> 1) | ({7'd0, owner} << clen);
								push_op.len  = {1'b0, clen} + 4'd1;
							end
						end
						default: ;
					endcase
				end
			end
			bphp_pkg::FR_HDR2: begin
				if (!q_full) begin
					push         = 1'b1;
					push_op.bits = {1'b0, sq2_q};
					push_op.len  = 4'd7;
				end
			end
			bphp_pkg::FR_FIN: begin
				if (step_q == bphp_pkg::BOX_STEPS) begin
					if (!q_full) begin
						push        = 1'b1;
						push_op.pad = 1'b1;
						push_op.fin = 1'b1;
					end
				end else if (box_rd == 5'd0) begin
					step_inc = 1'b1;
				end else if (!q_full) begin
					push         = 1'b1;
					dec_en       = 1'b1;
					push_op.fin  = 1'b1;
					push_op.bits = bphp_pkg::box_code(fin_pk);
					// trailing zero bit for every type but gold
					push_op.len  = {1'b0, bphp_pkg::box_len(fin_pk)}
						+ ((fin_pk == bphp_pkg::PIECE_GOLD) ? 4'd0 : 4'd1);
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= bphp_pkg::FR_IDLE;
			step_q  <= '0;
			for (int i = 0; i < bphp_pkg::NUM_TYPES; i++) begin
				box_q[i] <= bphp_pkg::box_init(3'(i));
			end
		end else begin
			state_q <= state_n;
			if (accept && kind == bphp_pkg::KIND_FINISH) begin
				step_q <= '0;
			end else if (step_inc) begin
				step_q <= step_q + 3'd1;
			end
			if (state_q == bphp_pkg::FR_WAIT && done.done && done.record_done) begin
				for (int i = 0; i < bphp_pkg::NUM_TYPES; i++) begin
					box_q[i] <= bphp_pkg::box_init(3'(i));
				end
			end else if (dec_en && box_rd != 5'd0) begin
				box_q[rd_idx] <= box_rd - 5'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept && kind == bphp_pkg::KIND_HEADER) begin
			sq2_q <= second_king_square;
		end
	end

	always_comb begin
		box_ok = 1'b1;
		for (int i = 0; i < bphp_pkg::NUM_TYPES; i++) begin
			if (box_q[i] > bphp_pkg::box_init(3'(i))) begin
				box_ok = 1'b0;
			end
		end
	end

	a_box_bound: assert property (@(posedge clk) disable iff (!arst_n) box_ok)
		else $error("piece box counter above full set");

endmodule

FILE: hw/rtl/bphp_back.sv
// Bit packer: merges chunks into bytes, holds the final byte, pads and closes the record.
module bphp_back #(
	parameter int RECORD_BITS = 256
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                op_valid,
	input  bphp_pkg::op_t       op,
	output logic                pop,
	output bphp_pkg::done_t     done,
	output logic                out_valid,
	input  logic                out_stall,
	output logic [7:0]          out_byte,
	output logic                last,
	output logic [1:0]          status
);

	localparam int RECORD_BYTES = RECORD_BITS / 8;
	localparam int BW           = $clog2(RECORD_BYTES);
	localparam logic [BW-1:0] LAST_BYTE = BW'(RECORD_BYTES - 1);

	logic [7:0]                     acc_q;
	logic [3:0]                     fill_q;
	logic [BW-1:0]                  bytes_q;
	logic                           overrun_q;
	logic [bphp_pkg::CNT_W-1:0]     count_q;
	logic                           out_v_q;
	logic [7:0]                     out_byte_q;
	logic                           out_last_q;
	logic [1:0]                     out_status_q;

	logic                           adv;
	logic                           is_final;
	logic [15:0]                    wide;
	logic [4:0]                     total;
	logic [7:0]                     acc_n;
	logic [3:0]                     fill_n;
	logic [BW-1:0]                  bytes_n;
	logic                           overrun_n;
	logic [bphp_pkg::CNT_W-1:0]     count_n;
	logic                           emit;
	logic [7:0]                     emit_byte;
	logic                           emit_last;
	logic [1:0]                     emit_status;

	assign adv      = op_valid && (!out_v_q || !out_stall);
	assign is_final = (bytes_q == LAST_BYTE);
	assign wide     = {8'd0, acc_q} | ({8'd0, op.bits} << fill_q);
	assign total    = {1'b0, fill_q} + {1'b0, op.len};

	always_comb begin
		acc_n       = acc_q;
		fill_n      = fill_q;
		bytes_n     = bytes_q;
		overrun_n   = overrun_q;
		count_n     = count_q;
		emit        = 1'b0;
		emit_byte   = acc_q;
		emit_last   = 1'b0;
		emit_status = bphp_pkg::STATUS_OK;
		pop         = 1'b0;
		done        = '0;
		if (adv && !op.pad) begin
			pop = 1'b1;
			if (!is_final) begin
				if (total >= 5'd8) begin
					emit      = 1'b1;
					emit_byte = wide[7:0];
					acc_n     = wide[15:8];
					fill_n    = 4'(total - 5'd8);
					bytes_n   = bytes_q + 1'b1;
					if (op.fin) begin
						count_n = count_q + 1'b1;
					end
				end else begin
					acc_n  = wide[7:0];
					fill_n = total[3:0];
				end
			end else begin
				// final byte is held; bits past its eighth are dropped
				acc_n  = wide[7:0];
				fill_n = (total > 5'd8) ? 4'd8 : total[3:0];
				if (total > 5'd8) begin
					overrun_n = 1'b1;
				end
			end
		end else if (adv) begin
			if (count_q == bphp_pkg::CNT_W'(bphp_pkg::MAX_RESULTS)) begin
				// byte budget of this finish spent, record stays open
				pop         = 1'b1;
				count_n     = '0;
				done.done   = 1'b1;
			end else if (is_final) begin
				pop         = 1'b1;
				emit        = 1'b1;
				emit_last   = 1'b1;
				if (overrun_q) begin
					emit_status = bphp_pkg::STATUS_OVERRUN;
				end else if (fill_q == 4'd8) begin
					emit_status = bphp_pkg::STATUS_OK;
				end else begin
					emit_status = bphp_pkg::STATUS_SHORT;
				end
				acc_n            = '0;
				fill_n           = '0;
				bytes_n          = '0;
				overrun_n        = 1'b0;
				count_n          = '0;
				done.done        = 1'b1;
				done.record_done = 1'b1;
			end else begin
				emit    = 1'b1;
				acc_n   = '0;
				fill_n  = '0;
				bytes_n = bytes_q + 1'b1;
				count_n = count_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q     <= '0;
			fill_q    <= '0;
			bytes_q   <= '0;
			overrun_q <= 1'b0;
			count_q   <= '0;
			out_v_q   <= 1'b0;
		end else begin
			acc_q     <= acc_n;
			fill_q    <= fill_n;
			bytes_q   <= bytes_n;
			overrun_q <= overrun_n;
			count_q   <= count_n;
			if (emit) begin
				out_v_q <= 1'b1;
			end else if (!out_stall) begin
				out_v_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			out_byte_q   <= emit_byte;
			out_last_q   <= emit_last;
			out_status_q <= emit_status;
		end
	end

	assign out_valid = out_v_q;
	assign out_byte  = out_byte_q;
	assign last      = out_last_q;
	assign status    = out_status_q;

	a_full_only_final: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q == 4'd8 |-> is_final)
		else $error("full accumulator outside the final byte");

	a_fill_range: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= 4'd8 && count_q <= bphp_pkg::CNT_W'(bphp_pkg::MAX_RESULTS))
		else $error("fill or byte budget out of range");

	a_close_clears: assert property (@(posedge clk) disable iff (!arst_n)
		done.record_done |=> bytes_q == '0 && fill_q == 4'd0 && !overrun_q)
		else $error("record state not cleared after final byte");

endmodule

FILE: sim/board_position_huffman_packer_tb.sv
// Self-checking testbench of the board position prefix-code packer, with scoreboard and stimulus.
typedef struct packed {
	logic [7:0] data;
	logic       last;
	logic [1:0] st;
} rec_byte_t;

// Predicts the packed record byte by byte and matches it against the block's output.
class record_scoreboard #(parameter int RECORD_BITS = 256);
	localparam int REC_BYTES = RECORD_BITS / 8;

	logic [7:0]  acc;
	int unsigned fill;
	int unsigned sent;
	logic [4:0]  box [7];
	bit          overrun;
	int unsigned step_bytes;

	logic [4:0] box_full [7];
	logic [7:0] sq_code [7];
	int         sq_len [7];
	logic [7:0] bx_code [7];
	int         bx_len [7];
	int         walk [7];

	rec_byte_t   bytes_due [$];
	int unsigned errors, matched, items, n_ok, n_over, n_short;

	function new();
		box_full = '{5'd18, 5'd4, 5'd4, 5'd4, 5'd2, 5'd2, 5'd4};
		sq_code  = '{8'h01, 8'h03, 8'h0b, 8'h07, 8'h1f, 8'h3f, 8'h0f};
		sq_len   = '{2, 4, 4, 4, 6, 6, 5};
		bx_code  = '{8'h02, 8'h09, 8'h0d, 8'h0b, 8'h2f, 8'h3f, 8'h1b};
		bx_len   = '{2, 4, 4, 4, 6, 6, 5};
		walk     = '{1, 2, 3, 4, 7, 5, 6};
		errors = 0; matched = 0; items = 0; n_ok = 0; n_over = 0; n_short = 0;
		clear();
	endfunction

	function void clear();
		acc = '0;
		fill = 0;
		sent = 0;
		overrun = 0;
		foreach (box[i]) box[i] = box_full[i];
	endfunction

	// anything written since the last record closed
	function bit open_record();
		if (sent != 0 || fill != 0 || overrun)
			return 1;
		for (int i = 0; i < 7; i++)
			if (box[i] != box_full[i])
				return 1;
		return 0;
	endfunction

	function bit final_full();
		return (sent + 1 >= REC_BYTES) && (fill >= 8);
	endfunction

	function void push(logic [7:0] d, logic l, logic [1:0] s);
		if (step_bytes < bphp_pkg::MAX_RESULTS)
			bytes_due.push_back('{data: d, last: l, st: s});
		step_bytes++;
	endfunction

	function void put_bit(logic b);
		if (final_full()) begin
			overrun = 1;
			return;
		end
		acc[fill] = b;
		fill++;
		// the final byte stays in the accumulator until finish
		if (fill >= 8 && sent + 1 < REC_BYTES) begin
			push(acc, 1'b0, bphp_pkg::STATUS_OK);
			acc = '0;
			fill = 0;
			sent++;
		end
	endfunction

	function void put_bits(logic [7:0] code, int len);
		for (int i = 0; i < len; i++)
			put_bit(code[i]);
	endfunction

	function void take(logic [2:0] pk);
		if (box[pk - 1] != 0)
			box[pk - 1]--;
	endfunction

	function void finish_record();
		int k;
		int n;
		bit is_short;
		for (int i = 0; i < 7; i++) begin
			k = walk[i];
			n = box[k - 1];
			while (n > 0) begin
				put_bits(bx_code[k - 1], bx_len[k - 1]);
				if (k != int'(bphp_pkg::PIECE_GOLD))
					put_bit(1'b0);
				n--;
			end
			box[k - 1] = '0;
		end
		is_short = !final_full();
		while (step_bytes < bphp_pkg::MAX_RESULTS) begin
			if (sent + 1 >= REC_BYTES) begin
				push(acc, 1'b1, overrun ? bphp_pkg::STATUS_OVERRUN
					: (is_short ? bphp_pkg::STATUS_SHORT : bphp_pkg::STATUS_OK));
				clear();
				return;
			end
			push(acc, 1'b0, bphp_pkg::STATUS_OK);
			acc = '0;
			fill = 0;
			sent++;
		end
	endfunction

	function void note_item(logic [1:0] k, logic [2:0] pk, logic pr, logic ow,
		logic tu, logic [6:0] fk, logic [6:0] sk);
		step_bytes = 0;
		items++;
		case (k)
			bphp_pkg::KIND_HEADER: begin
				put_bit(tu);
				put_bits({1'b0, fk}, 7);
				put_bits({1'b0, sk}, 7);
			end
			bphp_pkg::KIND_BOARD: begin
				if (pk == bphp_pkg::PIECE_EMPTY) begin
					put_bit(1'b0);
				end else begin
					put_bits(sq_code[pk - 1], sq_len[pk - 1]);
					if (pk != bphp_pkg::PIECE_GOLD)
						put_bit(pr);
					put_bit(ow);
					take(pk);
				end
			end
			bphp_pkg::KIND_HAND: begin
				if (pk != bphp_pkg::PIECE_EMPTY) begin
					put_bits(sq_code[pk - 1] >> 1, sq_len[pk - 1] - 1);
					if (pk != bphp_pkg::PIECE_GOLD)
						put_bit(1'b0);
					put_bit(ow);
					take(pk);
				end
			end
			default: finish_record();
		endcase
	endfunction

	function void report(string what, rec_byte_t e, logic [7:0] d, logic l, logic [1:0] s);
		errors++;
		if (errors <= 10)
			$display("%s: expected byte %h last %b status %0d, got byte %h last %b status %0d",
				what, e.data, e.last, e.st, d, l, s);
	endfunction

	function void check_byte(logic [7:0] d, logic l, logic [1:0] s);
		rec_byte_t e;
		if (bytes_due.size() == 0) begin
			report("unexpected byte", '0, d, l, s);
			return;
		end
		e = bytes_due.pop_front();
		if (e.data !== d || e.last !== l || e.st !== s) begin
			report("byte mismatch", e, d, l, s);
			return;
		end
		matched++;
		if (e.last) begin
			case (e.st)
				bphp_pkg::STATUS_OK:      n_ok++;
				bphp_pkg::STATUS_OVERRUN: n_over++;
				default:                  n_short++;
			endcase
		end
	endfunction
endclass

module board_position_huffman_packer_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int REC_BITS   = 256;
	localparam int STIM_ITEMS = 460;  // random part runs until this many transfers
	localparam int TAIL_ROOM  = 125;  // below this many left, only single items
	localparam int QUIET_FROM = 400;  // no idling on either side from here on
	localparam int LONG_HOLD  = 300;  // one long receiver hold-off, in cycles
	localparam int DRAIN_WAIT = 64;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;

	logic       in_valid = 1'b0;
	logic       in_stall;
	logic [1:0] kind = bphp_pkg::KIND_HEADER;
	logic [2:0] piece_kind = bphp_pkg::PIECE_EMPTY;
	logic       promoted = 1'b0;
	logic       owner = 1'b0;
	logic       turn = 1'b0;
	logic [6:0] first_king_square = '0;
	logic [6:0] second_king_square = '0;

	logic       out_valid;
	logic       out_stall = 1'b0;
	logic [7:0] out_byte;
	logic       last;
	logic [1:0] status;

	record_scoreboard #(REC_BITS) sb;

	int unsigned sent_items = 0;
	bit          quiet = 0;

	always #4 clk = ~clk;

	board_position_huffman_packer #(
		.RECORD_BITS(REC_BITS)
	) uut (
		.clk               (clk),
		.arst_n            (arst_n),
		.in_valid          (in_valid),
		.in_stall          (in_stall),
		.kind              (kind),
		.piece_kind        (piece_kind),
		.promoted          (promoted),
		.owner             (owner),
		.turn              (turn),
		.first_king_square (first_king_square),
		.second_king_square(second_king_square),
		.out_valid         (out_valid),
		.out_stall         (out_stall),
		.out_byte          (out_byte),
		.last              (last),
		.status            (status)
	);

	// Output monitor: values read right after the edge are the ones the edge saw,
	// so a transfer happened exactly when valid was high and stall low.
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			sb.check_byte(out_byte, last, status);
	end

	// One input transfer. An optional idle burst comes first; the payload then
	// holds until the block takes it, and only then does the predictor see it.
	task automatic send_item(input logic [1:0] k, input logic [2:0] pk, input logic pr,
		input logic ow, input logic tu, input logic [6:0] fk, input logic [6:0] sk);
		if (!quiet && $urandom_range(0, 4) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 13)) @(posedge clk);
		end
		in_valid           <= 1'b1;
		kind               <= k;
		piece_kind         <= pk;
		promoted           <= pr;
		owner              <= ow;
		turn               <= tu;
		first_king_square  <= fk;
		second_king_square <= sk;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		sb.note_item(k, pk, pr, ow, tu, fk, sk);
		sent_items++;
		if (sent_items >= QUIET_FROM)
			quiet = 1;
	endtask

	// fields a kind does not use are filled with noise
	task automatic send_piece(input logic [1:0] k, input logic [2:0] pk, input logic pr,
		input logic ow);
		send_item(k, pk, pr, ow, 1'($urandom), 7'($urandom), 7'($urandom));
	endtask

	task automatic send_header(input logic tu, input logic [6:0] fk, input logic [6:0] sk);
		send_item(bphp_pkg::KIND_HEADER, 3'($urandom), 1'($urandom), 1'($urandom), tu, fk, sk);
	endtask

	task automatic send_finish();
		send_item(bphp_pkg::KIND_FINISH, 3'($urandom), 1'($urandom), 1'($urandom),
			1'($urandom), 7'($urandom), 7'($urandom));
	endtask

	// A legal-looking position: every one of the 38 non-king pieces sits on the
	// board, in a hand or in the box, so with both kings present the record is
	// exactly full. A missing king adds one square and overruns by a bit.
	task automatic send_position();
		logic [2:0] sq_pk [81];
		logic       sq_pr [81];
		logic       sq_ow [81];
		bit         taken [81];
		bit         king [81];
		logic [2:0] hand_pk [$];
		logic       hand_ow [$];
		int         set_size [7];
		int         fk, sk, fk_out, s, r, bias;
		set_size = '{18, 4, 4, 4, 2, 2, 4};
		if (sb.open_record())
			send_finish();
		for (int i = 0; i < 81; i++) begin
			sq_pk[i] = bphp_pkg::PIECE_EMPTY;
			sq_pr[i] = 1'($urandom);
			sq_ow[i] = 1'($urandom);
			taken[i] = 0;
			king[i]  = 0;
		end
		fk = $urandom_range(0, 80);
		do sk = $urandom_range(0, 80); while (sk == fk);
		taken[fk] = 1; king[fk] = 1;
		taken[sk] = 1; king[sk] = 1;
		fk_out = fk;
		if ($urandom_range(0, 9) == 0) begin
			taken[fk] = 0;
			king[fk]  = 0;
			fk_out    = 81;
		end
		bias = $urandom_range(2, 8);
		for (int t = 1; t <= 7; t++) begin
			for (int n = 0; n < set_size[t - 1]; n++) begin
				r = $urandom_range(0, 9);
				if (r < bias) begin
					do s = $urandom_range(0, 80); while (taken[s]);
					taken[s] = 1;
					sq_pk[s] = 3'(t);
					sq_pr[s] = (t == int'(bphp_pkg::PIECE_GOLD)) ? 1'b0 : 1'($urandom);
					sq_ow[s] = 1'($urandom);
				end else if (r < bias + (10 - bias) / 2) begin
					hand_pk.push_back(3'(t));
					hand_ow.push_back(1'($urandom));
				end
			end
		end
		send_header(1'($urandom), 7'(fk_out), 7'(sk));
		for (int i = 0; i < 81; i++)
			if (!king[i])
				send_piece(bphp_pkg::KIND_BOARD, sq_pk[i], sq_pr[i], sq_ow[i]);
		foreach (hand_pk[i])
			send_piece(bphp_pkg::KIND_HAND, hand_pk[i], 1'($urandom), hand_ow[i]);
		send_finish();
	endtask

	// Broken record: random mix of kinds and pieces, usually far too many pieces
	// (overrun, saturated counters) or far too few (short); sometimes left open.
	task automatic send_broken();
		int          n, r;
		logic [1:0]  k;
		logic [2:0]  pk;
		n = $urandom_range(1, 70);
		if ($urandom_range(0, 1) == 0)
			send_header(1'($urandom), 7'($urandom), 7'($urandom));
		repeat (n) begin
			r = $urandom_range(0, 9);
			k = (r < 7) ? bphp_pkg::KIND_BOARD
				: (r < 9) ? bphp_pkg::KIND_HAND : bphp_pkg::KIND_HEADER;
			pk = ($urandom_range(0, 9) < 3) ? bphp_pkg::PIECE_EMPTY
				: 3'($urandom_range(1, 7));
			send_item(k, pk, 1'($urandom), 1'($urandom), 1'($urandom), 7'($urandom),
				7'($urandom));
		end
		if ($urandom_range(0, 9) != 0)
			send_finish();
	endtask

	// Receiver: random stall bursts and free runs, one long hold-off that backs
	// the block up to its input, and no stalls at all in the quiet tail.
	initial begin
		bit held;
		held = 0;
		wait (arst_n);
		@(posedge clk);
		forever begin
			if (quiet) begin
				out_stall <= 1'b0;
				@(posedge clk);
			end else if (!held && sent_items >= 120) begin
				held = 1;
				out_stall <= 1'b1;
				repeat (LONG_HOLD) @(posedge clk);
			end else if ($urandom_range(0, 2) == 0) begin
				out_stall <= 1'b1;
				repeat ($urandom_range(1, 13)) @(posedge clk);
			end else begin
				out_stall <= 1'b0;
				repeat ($urandom_range(1, 24)) @(posedge clk);
			end
		end
	end

	initial begin
		sb = new();
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: king square extremes, every piece on board and in hand,
		// gold with promote set, empty hand, short record, empty-record finish
		send_header(1'b1, 7'd127, 7'd0);
		send_header(1'b0, 7'd0, 7'd127);
		send_header(1'b1, 7'd81, 7'd81);
		for (int p = 0; p < 8; p++)
			send_piece(bphp_pkg::KIND_BOARD, 3'(p), 1'(p), ~1'(p));
		for (int p = 0; p < 8; p++)
			send_piece(bphp_pkg::KIND_HAND, 3'(p), 1'b1, 1'(p >> 1));
		send_finish();
		send_finish();

		// random: mostly whole positions, the rest broken records and noise;
		// close to the end only single items so the count lands near the target
		while (sent_items < STIM_ITEMS) begin
			case ((STIM_ITEMS - sent_items < TAIL_ROOM) ? 9 : $urandom_range(0, 9))
				0, 1, 2, 3, 4, 5: send_position();
				6, 7:             send_broken();
				default:          send_item(2'($urandom), 3'($urandom), 1'($urandom),
					1'($urandom), 1'($urandom), 7'($urandom), 7'($urandom));
			endcase
		end
		in_valid <= 1'b0;

		while (sb.bytes_due.size() != 0)
			@(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);

		$display("covered %0d input transfers, %0d records closed (%0d ok, %0d overrun, %0d short)",
			sb.items, sb.n_ok + sb.n_over + sb.n_short, sb.n_ok, sb.n_over, sb.n_short);
		$display("%0d output bytes matched, %0d mismatches, %0d bytes never seen",
			sb.matched, sb.errors, sb.bytes_due.size());
		if (sb.errors == 0 && sb.bytes_due.size() == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

	// watchdog, far beyond the slowest correct run
	initial begin
		#(20_000_000);
		$display("timeout with %0d bytes still expected", sb.bytes_due.size());
		$display("status: fail");
		$finish;
	end
endmodule

FILE: files.f
hw/rtl/bphp_pkg.sv
hw/rtl/bphp_fifo.sv
hw/rtl/bphp_front.sv
hw/rtl/bphp_back.sv
hw/rtl/board_position_huffman_packer.sv
sim/board_position_huffman_packer_tb.sv
